// File: rtl/core/bcd_pkg.sv
// Shared types and constants for the bounded circular deque unit.
// Holds the request/response payloads, command codes and the
// controller-to-datapath control struct. No dependencies.
package bcd_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int CAP_W  = 11;
   localparam int OCC_W  = 11;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;

   localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE_REAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY        = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] value;
   } bcd_req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
      logic [OCC_W-1:0]         occupancy;
   } bcd_rsp_type;

   // Control from the sequencer to the datapath, one step per flag.
   typedef struct packed {
      logic latch;
      logic exec;
      logic read;
      logic load;
   } bcd_ctl_type;

endpackage

// File: rtl/core/bcd_ram.sv
// Generic single-write, dual-read memory with registered read data.
// Standalone; no package dependency.
module bcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/core/bcd_ctrl.sv
// Sequencer for the deque: accept, update, read, respond.
// Depends on bcd_pkg for the control struct.
module bcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bcd_pkg::bcd_ctl_type ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl.latch = (state_ff == ST_IDLE) && req_valid;
      ctl.exec  = (state_ff == ST_EXEC);
      ctl.read  = (state_ff == ST_READ);
      ctl.load  = (state_ff == ST_LOAD) && rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_READ;
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drop valid once taken; set it again when a new response loads.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A pending, stalled response is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(ctl.load && rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   // Every accepted request reaches the read step, by way of the exec step.
   a_req_to_read: assert property (@(posedge clock) disable iff (reset)
      ctl.latch |=> ##1 ctl.read)
      else $error("request did not reach the read step");

endmodule

// File: rtl/core/bcd_datapath.sv
// Deque datapath: head pointer, count, capacity, ring storage and
// the response register. Depends on bcd_pkg and bcd_ram.
module bcd_datapath #(
   parameter int DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bcd_pkg::bcd_ctl_type ctl,
   input  bcd_pkg::bcd_req_type req_payload,
   input  logic                 csr_wr_en,
   input  logic [bcd_pkg::CAP_W-1:0] csr_wr_data,
   output bcd_pkg::bcd_rsp_type rsp_payload
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = AW + 1;
   localparam int CMP_W = (CNT_W > bcd_pkg::CAP_W) ? CNT_W : bcd_pkg::CAP_W;

   logic [bcd_pkg::CMD_W-1:0]  cmd_ff;
   logic [bcd_pkg::DATA_W-1:0] value_ff;
   logic [AW-1:0]              head_ff;
   logic [AW-1:0]              head_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic [bcd_pkg::CAP_W-1:0]  cap_ff;
   logic                       ok_ff;
   logic                       ok_in;
   bcd_pkg::bcd_rsp_type       rsp_ff;
   bcd_pkg::bcd_rsp_type       rsp_in;

   logic [CMP_W-1:0]           cap_ext;
   logic [CMP_W-1:0]           eff_cap;
   logic                       full;
   logic                       empty;
   logic [AW-1:0]              head_prev;
   logic [AW-1:0]              head_next;
   logic [SUM_W-1:0]           tail_sum;
   logic [AW-1:0]              tail_addr;
   logic [SUM_W-1:0]           rear_sum;
   logic [AW-1:0]              rear_addr;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [bcd_pkg::DATA_W-1:0] rd_front;
   logic [bcd_pkg::DATA_W-1:0] rd_rear;

   // Capacity saturates at the storage depth.
   assign cap_ext = CMP_W'(cap_ff);
   assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign full    = (CMP_W'(cnt_ff) >= eff_cap);
   assign empty   = (cnt_ff == '0);

   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Sums stay below twice the depth, so one conditional subtract wraps them.
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(cnt_ff);
   assign tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? AW'(tail_sum - SUM_W'(DEPTH))
                                                  : AW'(tail_sum);
   assign rear_sum  = tail_sum - 1'b1;
   assign rear_addr = (rear_sum >= SUM_W'(DEPTH)) ? AW'(rear_sum - SUM_W'(DEPTH))
                                                  : AW'(rear_sum);

   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      ok_in   = 1'b1;
      wr_en   = 1'b0;
      wr_addr = tail_addr;
      unique case (cmd_ff)
         bcd_pkg::CMD_INSERT_FRONT: begin
            wr_addr = head_prev;
            if (full) begin
               ok_in = 1'b0;
            end else begin
               head_in = head_prev;
               cnt_in  = cnt_ff + 1'b1;
               wr_en   = ctl.exec;
            end
         end
         bcd_pkg::CMD_INSERT_REAR: begin
            if (full) begin
               ok_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               wr_en  = ctl.exec;
            end
         end
         bcd_pkg::CMD_DELETE_FRONT: begin
            if (empty) begin
               ok_in = 1'b0;
            end else begin
               head_in = head_next;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         bcd_pkg::CMD_DELETE_REAR: begin
            if (empty) begin
               ok_in = 1'b0;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            // query and unused codes: state unchanged, always succeed
         end
      endcase
   end

   always_comb begin
      rsp_in.ok          = ok_ff;
      rsp_in.front_value = empty ? '1 : rd_front;
      rsp_in.rear_value  = empty ? '1 : rd_rear;
      rsp_in.is_empty    = empty;
      rsp_in.is_full     = full;
      rsp_in.occupancy   = bcd_pkg::OCC_W'(cnt_ff);
   end

   bcd_ram #(
      .WIDTH(bcd_pkg::DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (value_ff),
      .rd_en     (ctl.read),
      .rd_addr_a (head_ff),
      .rd_addr_b (rear_addr),
      .rd_data_a (rd_front),
      .rd_data_b (rd_rear)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
         cap_ff  <= bcd_pkg::CAPACITY_RESET;
      end else begin
         if (ctl.exec) begin
            head_ff <= head_in;
            cnt_ff  <= cnt_in;
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff   <= req_payload.command;
         value_ff <= req_payload.value;
      end
      if (ctl.exec) begin
         ok_ff <= ok_in;
      end
      if (ctl.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(cnt_ff) <= CMP_W'(DEPTH))
      else $error("entry count beyond depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(head_ff) < SUM_W'(DEPTH))
      else $error("head pointer beyond depth");

   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      ctl.exec && !ok_in |=> $stable(cnt_ff) && $stable(head_ff))
      else $error("failed command changed the queue");

endmodule

// File: rtl/core/bounded_circular_deque_unit.sv
// Bounded circular deque unit, top level.
// Depends on bcd_pkg, bcd_ctrl, bcd_datapath (which holds bcd_ram).
//
// Usage:
//   Request channel (req_valid / req_stall / req_payload): one command and
//   value per request: insert front, insert rear, delete front, delete rear
//   or query. Codes 5 to 7 act as a query.
//   Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one
//   response per request, in order, giving success, front and rear values
//   (all ones when empty), empty and full flags and the occupancy after
//   the command.
//   CSR port: csr_wr_en with csr_wr_data writes the capacity (reset 1024,
//   saturated at DEPTH). Write it only while no request is in flight.
// Timing:
//   The unit takes a new request only once the last one has passed its
//   steps: pointer update, then the storage read of front and rear with
//   its registered output, then the response register. A request may be
//   accepted while the previous response is still held; a stalled
//   response holds and backs up further requests.
// Reset: synchronous, clears the pointers and count and restores the
//   capacity; storage contents are left as they are and need no clearing.
module bounded_circular_deque_unit #(
   parameter int DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bcd_pkg::bcd_req_type         req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bcd_pkg::bcd_rsp_type         rsp_payload,
   input  logic                         csr_wr_en,
   input  logic [bcd_pkg::CAP_W-1:0]    csr_wr_data
);

   bcd_pkg::bcd_ctl_type ctl;

   bcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   bcd_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: dv/bounded_circular_deque_unit_tb.sv
// Testbench for bounded_circular_deque_unit: directed and random requests,
// each response checked in order against a shadow deque kept in the bench.
// Depends on bcd_pkg and the bounded_circular_deque_unit RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH  = 1024;
   localparam int RSP_LATENCY = 3;

   localparam logic [bcd_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [bcd_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [bcd_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   bcd_pkg::bcd_req_type      req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   bcd_pkg::bcd_rsp_type      rsp_payload;
   logic                      csr_wr_en   = 1'b0;
   logic [bcd_pkg::CAP_W-1:0] csr_wr_data = '0;

   // Shadow deque: ring storage, front pointer, count and capacity.
   logic [bcd_pkg::DATA_W-1:0] ring [RING_DEPTH];
   logic [9:0]                 ring_head;
   logic [bcd_pkg::OCC_W-1:0]  ring_count;
   logic [bcd_pkg::CAP_W-1:0]  cap_reg;
   bcd_pkg::bcd_rsp_type       predicted_status [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int hold_left;
   int mismatch_count;
   int rsp_index;

   always #6 clock = ~clock;

   bounded_circular_deque_unit #(
      .DEPTH(RING_DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Receiver: random stalls, or a long hold when one is requested.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: response %0d: %s", $realtime, rsp_index, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : rsp_checker
      bcd_pkg::bcd_rsp_type want;
      if (!reset && rsp_valid !== 1'b0 && !rsp_stall) begin
         if (predicted_status.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = predicted_status[0];
            predicted_status.delete(0);
            if (rsp_payload.ok !== want.ok)
               report_mismatch($sformatf("ok %b, want %b", rsp_payload.ok, want.ok));
            if (rsp_payload.front_value !== want.front_value)
               report_mismatch($sformatf("front_value %h, want %h",
                                         rsp_payload.front_value, want.front_value));
            if (rsp_payload.rear_value !== want.rear_value)
               report_mismatch($sformatf("rear_value %h, want %h",
                                         rsp_payload.rear_value, want.rear_value));
            if (rsp_payload.is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty %b, want %b",
                                         rsp_payload.is_empty, want.is_empty));
            if (rsp_payload.is_full !== want.is_full)
               report_mismatch($sformatf("is_full %b, want %b",
                                         rsp_payload.is_full, want.is_full));
            if (rsp_payload.occupancy !== want.occupancy)
               report_mismatch($sformatf("occupancy %0d, want %0d",
                                         rsp_payload.occupancy, want.occupancy));
         end
         rsp_index++;
      end
   end

   // Apply one command to the shadow deque and return the status after it.
   function automatic bcd_pkg::bcd_rsp_type apply_command(
         input logic [bcd_pkg::CMD_W-1:0]  cmd,
         input logic [bcd_pkg::DATA_W-1:0] val);
      bcd_pkg::bcd_rsp_type      status;
      logic [bcd_pkg::CAP_W-1:0] limit;
      logic [9:0]                slot;
      limit = (cap_reg > RING_DEPTH) ? bcd_pkg::CAP_W'(RING_DEPTH) : cap_reg;
      status.ok = 1'b1;
      case (cmd)
         bcd_pkg::CMD_INSERT_FRONT: begin
            if (ring_count >= limit) begin
               status.ok = 1'b0;
            end else begin
               ring_head = ring_head - 10'd1;
               ring[ring_head] = val;
               ring_count++;
            end
         end
         bcd_pkg::CMD_INSERT_REAR: begin
            if (ring_count >= limit) begin
               status.ok = 1'b0;
            end else begin
               slot = ring_head + ring_count[9:0];
               ring[slot] = val;
               ring_count++;
            end
         end
         bcd_pkg::CMD_DELETE_FRONT: begin
            if (ring_count == 0) begin
               status.ok = 1'b0;
            end else begin
               ring_head = ring_head + 10'd1;
               ring_count--;
            end
         end
         bcd_pkg::CMD_DELETE_REAR: begin
            if (ring_count == 0)
               status.ok = 1'b0;
            else
               ring_count--;
         end
         default: ;
      endcase
      status.is_empty = (ring_count == 0);
      status.is_full = (ring_count >= limit);
      status.occupancy = ring_count;
      if (status.is_empty) begin
         status.front_value = '1;
         status.rear_value = '1;
      end else begin
         // count of a full ring wraps to zero here, which still lands on the tail
         slot = ring_head + ring_count[9:0] - 10'd1;
         status.front_value = ring[ring_head];
         status.rear_value = ring[slot];
      end
      return status;
   endfunction

   task automatic issue_request(input logic [bcd_pkg::CMD_W-1:0]  cmd,
                                input logic [bcd_pkg::DATA_W-1:0] val);
      bcd_pkg::bcd_req_type cmd_word;
      cmd_word.command = cmd;
      cmd_word.value = val;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= cmd_word;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted_status = {predicted_status, apply_command(cmd, val)};
   endtask

   // Drop valid, wait for every response, then let the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_status.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [bcd_pkg::CAP_W-1:0] cap);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_reg = cap;
   endtask

   task automatic run_command_mix(input int n_items, input int push_pct);
      int                        roll;
      logic [bcd_pkg::CMD_W-1:0] cmd;
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            cmd = $urandom_range(0, 1) ? bcd_pkg::CMD_INSERT_REAR
                                       : bcd_pkg::CMD_INSERT_FRONT;
         else if (roll < 92)
            cmd = $urandom_range(0, 1) ? bcd_pkg::CMD_DELETE_REAR
                                       : bcd_pkg::CMD_DELETE_FRONT;
         else
            cmd = bcd_pkg::CMD_W'($urandom_range(bcd_pkg::CMD_QUERY, CMD_SPARE_7));
         issue_request(cmd, $urandom);
      end
   endtask

   task automatic test_directed();
      issue_request(bcd_pkg::CMD_QUERY, 32'h0000_0000);
      issue_request(bcd_pkg::CMD_DELETE_FRONT, 32'h1234_5678);
      issue_request(bcd_pkg::CMD_DELETE_REAR, 32'hFFFF_FFFF);
      issue_request(CMD_SPARE_5, 32'h8000_0000);
      issue_request(bcd_pkg::CMD_INSERT_FRONT, 32'h7FFF_FFFF);
      issue_request(bcd_pkg::CMD_INSERT_REAR, 32'h8000_0000);
      issue_request(bcd_pkg::CMD_INSERT_FRONT, 32'hFFFF_FFFF);
      issue_request(bcd_pkg::CMD_INSERT_REAR, 32'h0000_0000);
      issue_request(bcd_pkg::CMD_QUERY, 32'hDEAD_BEEF);
      issue_request(bcd_pkg::CMD_DELETE_FRONT, 32'h0);
      issue_request(bcd_pkg::CMD_DELETE_REAR, 32'h0);
      issue_request(CMD_SPARE_6, 32'h5A5A_A5A5);
      issue_request(bcd_pkg::CMD_DELETE_FRONT, 32'h0);
      issue_request(bcd_pkg::CMD_DELETE_REAR, 32'h0);
      issue_request(bcd_pkg::CMD_DELETE_REAR, 32'h0);
      issue_request(CMD_SPARE_7, 32'hFFFF_FFFF);
      // single entry: front and rear are the same word
      issue_request(bcd_pkg::CMD_INSERT_REAR, 32'h5555_5555);
      issue_request(bcd_pkg::CMD_DELETE_FRONT, 32'h0);
      issue_request(bcd_pkg::CMD_INSERT_FRONT, 32'hAAAA_AAAA);
      issue_request(bcd_pkg::CMD_DELETE_REAR, 32'h0);
      settle();
   endtask

   task automatic test_capacity_limits();
      write_capacity(11'd1);
      issue_request(bcd_pkg::CMD_INSERT_REAR, $urandom);
      issue_request(bcd_pkg::CMD_INSERT_FRONT, $urandom);
      issue_request(bcd_pkg::CMD_QUERY, $urandom);
      issue_request(bcd_pkg::CMD_DELETE_FRONT, $urandom);
      issue_request(bcd_pkg::CMD_DELETE_REAR, $urandom);
      // zero capacity: always full, every insert refused
      write_capacity('0);
      issue_request(bcd_pkg::CMD_INSERT_FRONT, $urandom);
      issue_request(bcd_pkg::CMD_INSERT_REAR, $urandom);
      issue_request(bcd_pkg::CMD_QUERY, $urandom);
      write_capacity(11'd8);
      for (int i = 0; i < 6; i++)
         issue_request($urandom_range(0, 1) ? bcd_pkg::CMD_INSERT_FRONT
                                            : bcd_pkg::CMD_INSERT_REAR, $urandom);
      // shrink below the count: full, inserts refused, deletes still work
      write_capacity(11'd2);
      issue_request(bcd_pkg::CMD_INSERT_REAR, $urandom);
      issue_request(bcd_pkg::CMD_QUERY, $urandom);
      for (int i = 0; i < 3; i++)
         issue_request(bcd_pkg::CMD_DELETE_FRONT, $urandom);
      issue_request(bcd_pkg::CMD_INSERT_FRONT, $urandom);
      issue_request(bcd_pkg::CMD_DELETE_REAR, $urandom);
      issue_request(bcd_pkg::CMD_DELETE_REAR, $urandom);
      issue_request(bcd_pkg::CMD_INSERT_FRONT, $urandom);
      write_capacity(bcd_pkg::CAPACITY_RESET);
      for (int i = 0; i < 3; i++)
         issue_request(bcd_pkg::CMD_DELETE_REAR, $urandom);
      settle();
   endtask

   task automatic test_backpressure();
      settle();
      hold_request = 300;
      run_command_mix(24, 60);
      settle();
   endtask

   task automatic test_random_traffic(input int n_items);
      int                        sent;
      int                        seg;
      int                        roll;
      logic [bcd_pkg::CAP_W-1:0] cap;
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            cap = '0;
         else if (roll < 14)
            cap = bcd_pkg::CAPACITY_RESET;
         else if (roll < 20)
            cap = '1;
         else if (roll < 28)
            cap = 11'd1;
         else if (roll < 85)
            cap = bcd_pkg::CAP_W'($urandom_range(2, 24));
         else
            cap = bcd_pkg::CAP_W'($urandom_range(0, 2047));
         write_capacity(cap);
         // fill toward full, then drain toward empty
         seg = $urandom_range(20, 50);
         run_command_mix(seg, 70);
         run_command_mix(seg, 25);
         sent += 2 * seg;
      end
      settle();
   endtask

   initial begin
      ring_head = '0;
      ring_count = '0;
      cap_reg = bcd_pkg::CAPACITY_RESET;
      send_idle_pct = 36;
      recv_idle_pct = 56;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_limits();
      test_backpressure();
      test_random_traffic(230);
      send_idle_pct = 56;
      recv_idle_pct = 36;
      test_random_traffic(230);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(230);
      settle();
      if (mismatch_count == 0)
         $display("** bounded_circular_deque_unit: PASSED **");
      else
         $display("** bounded_circular_deque_unit: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** bounded_circular_deque_unit: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/bcd_pkg.sv
rtl/core/bcd_ram.sv
rtl/core/bcd_ctrl.sv
rtl/core/bcd_datapath.sv
rtl/core/bounded_circular_deque_unit.sv
dv/bounded_circular_deque_unit_tb.sv
